[hdl/rwl_pkg.sv]
// Shared types, constants and helper function of the readers-writers lock manager.
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int ID_W        = 4;
    localparam int READER_IDS  = 8;
    localparam int WRITER_IDS  = 16;
    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int READERS_W   = 4;
    localparam int READERS_MAX = 15;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = 1;
    localparam int CMDQ_CNT_W  = 2;

    typedef enum logic [1:0] {
        OP_START_READ  = 2'd0,
        OP_STOP_READ   = 2'd1,
        OP_START_WRITE = 2'd2,
        OP_STOP_WRITE  = 2'd3
    } rwl_op_t;

    typedef enum logic [1:0] {
        RESP_GRANT  = 2'd0,
        RESP_ACK    = 2'd1,
        RESP_FULL   = 2'd2,
        RESP_NOHOLD = 2'd3
    } rwl_resp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } rwl_state_t;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        logic            start;
        logic            writer;
        logic [ID_W-1:0] id;
    } rwl_cmd_t;

    // One wait queue entry.
    typedef struct packed {
        logic            writer;
        logic [ID_W-1:0] id;
    } rwl_entry_t;

    // A writer needs the lock free; a reader needs no writer and room in the reader count.
    function automatic logic can_grant(logic writer_held, logic [READERS_W-1:0] readers,
                                       logic writer);
        logic ok;
        if (writer_held)
            ok = 1'b0;
        else if (writer)
            ok = (readers == '0);
        else
            ok = (readers < READERS_W'(READERS_MAX));
        return ok;
    endfunction

endpackage

[hdl/rwl_front.sv]
// Front end: decodes and range-checks incoming lock requests.
`timescale 1ns / 1ps

module rwl_front (
    input  logic [1:0]                    operation,
    input  logic [rwl_pkg::ID_W-1:0]      requester_id,
    input  logic                          req_valid,
    output logic                          push_valid,
    output rwl_pkg::rwl_cmd_t             push_cmd
);

    logic writer;
    logic in_range;

    always_comb
    begin
        writer = (operation == rwl_pkg::OP_START_WRITE) || (operation == rwl_pkg::OP_STOP_WRITE);
        if (writer)
            in_range = ({1'b0, requester_id} < (rwl_pkg::ID_W + 1)'(rwl_pkg::WRITER_IDS));
        else
            in_range = ({1'b0, requester_id} < (rwl_pkg::ID_W + 1)'(rwl_pkg::READER_IDS));

        // Requests from ids outside their space are swallowed here.
        push_valid      = req_valid && in_range;
        push_cmd.start  = (operation == rwl_pkg::OP_START_READ) ||
                          (operation == rwl_pkg::OP_START_WRITE);
        push_cmd.writer = writer;
        push_cmd.id     = requester_id;
    end

endmodule

[hdl/rwl_cmd_fifo.sv]
// Short command queue that decouples the front end from the lock engine.
`timescale 1ns / 1ps

module rwl_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rwl_pkg::rwl_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output rwl_pkg::rwl_cmd_t pop_cmd
);

    rwl_pkg::rwl_cmd_t                    entries_reg [rwl_pkg::CMDQ_DEPTH];
    logic [rwl_pkg::CMDQ_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [rwl_pkg::CMDQ_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [rwl_pkg::CMDQ_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                 do_push;
    logic                                 do_pop;

    always_comb
    begin
        full        = (cnt_reg == rwl_pkg::CMDQ_CNT_W'(rwl_pkg::CMDQ_DEPTH));
        pop_valid   = (cnt_reg != '0);
        pop_cmd     = entries_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && pop_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + rwl_pkg::CMDQ_CNT_W'(do_push) - rwl_pkg::CMDQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[hdl/rwl_back.sv]
// Lock engine: hold counts, FIFO wait queue, grant drain and the response register.
`timescale 1ns / 1ps

module rwl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  rwl_pkg::rwl_cmd_t             cmd,
    output logic                          cmd_pop,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [rwl_pkg::ID_W-1:0]      target_id,
    output logic                          target_is_writer,
    output logic [1:0]                    response,
    output logic                          last
);

    localparam int QW = rwl_pkg::QPTR_W;
    localparam int CW = rwl_pkg::QCNT_W;
    localparam int RW = rwl_pkg::READERS_W;

    rwl_pkg::rwl_state_t        state_reg, state_next;
    logic [RW-1:0]              readers_reg, readers_next;
    logic                       writer_reg, writer_next;
    logic [QW-1:0]              head_reg, head_next;
    logic [QW-1:0]              tail_reg, tail_next;
    logic [CW-1:0]              count_reg, count_next;

    rwl_pkg::rwl_entry_t        queue_mem [rwl_pkg::QUEUE_DEPTH];
    rwl_pkg::rwl_entry_t        head_entry_reg;
    logic                       mem_we;

    // Response that is decided but not yet loaded into the output register.
    logic [rwl_pkg::ID_W-1:0]   pend_id_reg, pend_id_next;
    logic                       pend_wr_reg, pend_wr_next;
    rwl_pkg::rwl_resp_t         pend_resp_reg, pend_resp_next;

    logic                       out_valid_reg, out_valid_next;
    logic [rwl_pkg::ID_W-1:0]   out_id_reg, out_id_next;
    logic                       out_wr_reg, out_wr_next;
    rwl_pkg::rwl_resp_t         out_resp_reg, out_resp_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_free;
    logic                       out_load;

    function automatic logic [QW-1:0] ring_next(logic [QW-1:0] idx);
        logic [QW-1:0] n;
        if (idx == QW'(rwl_pkg::QUEUE_DEPTH - 1))
            n = '0;
        else
            n = idx + 1'b1;
        return n;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        readers_next   = readers_reg;
        writer_next    = writer_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        pend_id_next   = pend_id_reg;
        pend_wr_next   = pend_wr_reg;
        pend_resp_next = pend_resp_reg;
        out_id_next    = out_id_reg;
        out_wr_next    = out_wr_reg;
        out_resp_next  = out_resp_reg;
        out_last_next  = out_last_reg;
        out_free       = !out_valid_reg || !rsp_stall;
        out_load       = 1'b0;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            rwl_pkg::ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.start)
                    begin
                        if (count_reg == '0 &&
                            rwl_pkg::can_grant(writer_reg, readers_reg, cmd.writer))
                        begin
                            if (cmd.writer)
                                writer_next = 1'b1;
                            else
                                readers_next = readers_reg + 1'b1;
                            out_load      = 1'b1;
                            out_id_next   = cmd.id;
                            out_wr_next   = cmd.writer;
                            out_resp_next = rwl_pkg::RESP_GRANT;
                            out_last_next = 1'b1;
                        end
                        else if (count_reg == CW'(rwl_pkg::QUEUE_DEPTH))
                        begin
                            out_load      = 1'b1;
                            out_id_next   = cmd.id;
                            out_wr_next   = cmd.writer;
                            out_resp_next = rwl_pkg::RESP_FULL;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            // The queue head is blocked, so queuing never frees anything.
                            mem_we     = 1'b1;
                            tail_next  = ring_next(tail_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pend_id_next = cmd.id;
                        pend_wr_next = cmd.writer;
                        if (cmd.writer ? !writer_reg : (readers_reg == '0))
                            pend_resp_next = rwl_pkg::RESP_NOHOLD;
                        else
                        begin
                            pend_resp_next = rwl_pkg::RESP_ACK;
                            if (cmd.writer)
                                writer_next = 1'b0;
                            else
                                readers_next = readers_reg - 1'b1;
                        end
                        state_next = rwl_pkg::ST_READ;
                    end
                end
            end

            rwl_pkg::ST_READ:
            begin
                // Head entry is fetched from the queue memory during this cycle.
                state_next = rwl_pkg::ST_CHECK;
            end

            rwl_pkg::ST_CHECK:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_id_next   = pend_id_reg;
                    out_wr_next   = pend_wr_reg;
                    out_resp_next = pend_resp_reg;
                    if (count_reg != '0 &&
                        rwl_pkg::can_grant(writer_reg, readers_reg, head_entry_reg.writer))
                    begin
                        out_last_next = 1'b0;
                        if (head_entry_reg.writer)
                            writer_next = 1'b1;
                        else
                            readers_next = readers_reg + 1'b1;
                        head_next      = ring_next(head_reg);
                        count_next     = count_reg - 1'b1;
                        pend_id_next   = head_entry_reg.id;
                        pend_wr_next   = head_entry_reg.writer;
                        pend_resp_next = rwl_pkg::RESP_GRANT;
                        state_next     = rwl_pkg::ST_READ;
                    end
                    else
                    begin
                        out_last_next = 1'b1;
                        state_next    = rwl_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = rwl_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwl_pkg::ST_IDLE;
            readers_reg   <= '0;
            writer_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            readers_reg   <= readers_next;
            writer_reg    <= writer_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        pend_wr_reg   <= pend_wr_next;
        pend_resp_reg <= pend_resp_next;
        out_id_reg    <= out_id_next;
        out_wr_reg    <= out_wr_next;
        out_resp_reg  <= out_resp_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[tail_reg].writer <= cmd.writer;
            queue_mem[tail_reg].id     <= cmd.id;
        end
        head_entry_reg <= queue_mem[head_reg];
    end

    assign rsp_valid        = out_valid_reg;
    assign target_id        = out_id_reg;
    assign target_is_writer = out_wr_reg;
    assign response         = out_resp_reg;
    assign last             = out_last_reg;

endmodule

[hdl/fifo_fair_readers_writers_lock_top.sv]
// Top level of the fair readers-writers lock manager.
`timescale 1ns / 1ps

// Usage: the request channel (req_valid, req_stall) carries one word per lock
// request: operation and requester_id. The response channel (rsp_valid, rsp_stall)
// carries one word per response: target_id, target_is_writer, response and last.
// A request whose id is outside its reader or writer space is accepted and dropped.
// A start request that must wait is queued and answered later by a grant word.
// Every response burst caused by one request ends with a word that has last set.
// An immediate grant or queue-full refusal is loaded from the command queue straight
// into the response register; a release answer first passes the ST_READ and ST_CHECK
// states, and each grant it frees from the wait queue passes them again after the
// word before it, since each grant reads one wait queue entry from the queue memory.
// The lock engine works on one request at a time. A two-word command queue lets the
// request side keep accepting while the engine is busy or the receiver stalls.
// While rsp_stall is high a valid response word holds and the engine waits; once the
// command queue is full, req_stall rises. Reset clears all hold counts, empties the
// wait queue and command queue and drops any pending response; no clearing pass.
module fifo_fair_readers_writers_lock_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    operation,
    input  logic [rwl_pkg::ID_W-1:0]      requester_id,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [rwl_pkg::ID_W-1:0]      target_id,
    output logic                          target_is_writer,
    output logic [1:0]                    response,
    output logic                          last
);

    logic              push_valid;
    rwl_pkg::rwl_cmd_t push_cmd;
    logic              cmdq_full;
    logic              cmd_valid;
    rwl_pkg::rwl_cmd_t cmd;
    logic              cmd_pop;

    // The front end decodes the word and filters out-of-range ids.
    rwl_front u_front (
        .operation    (operation),
        .requester_id (requester_id),
        .req_valid    (req_valid),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd)
    );

    // Words are accepted whenever the command queue has room.
    assign req_stall = cmdq_full;

    rwl_cmd_fifo u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_cmd  (push_cmd),
        .full      (cmdq_full),
        .pop       (cmd_pop),
        .pop_valid (cmd_valid),
        .pop_cmd   (cmd)
    );

    // The lock engine owns all lock state and the response register.
    rwl_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .target_id        (target_id),
        .target_is_writer (target_is_writer),
        .response         (response),
        .last             (last)
    );

endmodule

[hdl/rwl_checker.sv]
// Port-level checker for the lock manager and its bind to the top level.
`timescale 1ns / 1ps

module rwl_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [1:0]                    operation,
    input  logic [rwl_pkg::ID_W-1:0]      requester_id,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [rwl_pkg::ID_W-1:0]      target_id,
    input  logic                          target_is_writer,
    input  logic [1:0]                    response,
    input  logic                          last
);

    // A stalled request word stays offered and keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(operation) &&
                                   $stable(requester_id))
        else $error("request word changed while stalled");

    // A stalled response word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response word dropped while stalled");

    // A stalled response word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(target_id) && $stable(target_is_writer) &&
                                   $stable(response) && $stable(last))
        else $error("response word changed while stalled");

    // A refusal never frees the queue, so it always closes its burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && response == rwl_pkg::RESP_FULL |-> last)
        else $error("queue-full refusal not marked last");

    // Once a writer is granted nothing else can be granted in the same burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && response == rwl_pkg::RESP_GRANT && target_is_writer |-> last)
        else $error("writer grant followed by further responses");

endmodule

bind fifo_fair_readers_writers_lock_top rwl_checker u_rwl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .operation        (operation),
    .requester_id     (requester_id),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .target_id        (target_id),
    .target_is_writer (target_is_writer),
    .response         (response),
    .last             (last)
);
